FILE: hdl/itgi_pkg.sv
// Shared types, constants and arithmetic helpers for the IMU tilt and gyro integrator.
// No dependencies; used by itgi_axis, itgi_tilt and the top level.
package itgi_pkg;

    localparam int ACC_WIDTH_DEF    = 40;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int SENS_W = 12;
    localparam logic [SENS_W-1:0] SENS_RESET = 12'd1310;
    localparam int DIV_W  = 19;
    localparam int RATE_W = 16;
    localparam int TIME_W = 32;
    localparam int PROD_W = RATE_W + TIME_W;

    localparam int ANGLE_OUT_W = 40;
    localparam int ROLL_W      = 17;
    localparam int PITCH_W     = 16;

    localparam int CW = 42;
    localparam int ZW = 32;
    localparam int ROOT_STEPS = 24;
    localparam int ROOT_W     = 48;

    typedef logic signed [CW-1:0] cord_t;
    typedef logic signed [ZW-1:0] ang_t;

    localparam ang_t DEG90_Z   = 32'sd94371840;
    localparam ang_t ROLL_LIM  = 32'sd46080;
    localparam ang_t PITCH_LIM = 32'sd23040;

    typedef struct packed {
        cord_t x;
        cord_t y;
        ang_t  z;
    } cvec_t;

    typedef struct packed {
        logic                       done;
        logic signed [ROLL_W-1:0]   roll;
        logic signed [PITCH_W-1:0]  pitch;
    } tilt_t;

    function automatic ang_t atan_entry(input logic [4:0] idx);
        ang_t a;
        case (idx)
            5'd0:    a = 32'sd47185920;
            5'd1:    a = 32'sd27855475;
            5'd2:    a = 32'sd14718068;
            5'd3:    a = 32'sd7471121;
            5'd4:    a = 32'sd3750058;
            5'd5:    a = 32'sd1876857;
            5'd6:    a = 32'sd938658;
            5'd7:    a = 32'sd469357;
            5'd8:    a = 32'sd234682;
            5'd9:    a = 32'sd117342;
            5'd10:   a = 32'sd58671;
            5'd11:   a = 32'sd29335;
            5'd12:   a = 32'sd14668;
            5'd13:   a = 32'sd7334;
            5'd14:   a = 32'sd3667;
            5'd15:   a = 32'sd1833;
            5'd16:   a = 32'sd917;
            5'd17:   a = 32'sd458;
            5'd18:   a = 32'sd229;
            5'd19:   a = 32'sd115;
            5'd20:   a = 32'sd57;
            5'd21:   a = 32'sd29;
            5'd22:   a = 32'sd14;
            5'd23:   a = 32'sd7;
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic cvec_t cordic_step(input cvec_t v, input logic [4:0] i);
        cvec_t n;
        cord_t xs;
        cord_t ys;
        xs = v.x >>> i;
        ys = v.y >>> i;
        if (!v.y[CW-1])
        begin
            n.x = v.x + ys;
            n.y = v.y - xs;
            n.z = v.z + atan_entry(i);
        end
        else
        begin
            n.x = v.x - ys;
            n.y = v.y + xs;
            n.z = v.z - atan_entry(i);
        end
        return n;
    endfunction

    function automatic logic signed [ROLL_W-1:0] round_clamp(input ang_t z, input ang_t lim);
        ang_t r;
        r = (z + 32'sd2048) >>> 12;
        if (r > lim)
            r = lim;
        else if (r < -lim)
            r = -lim;
        return r[ROLL_W-1:0];
    endfunction

endpackage

FILE: hdl/itgi_axis.sv
// One gyro axis: shift-add rate times elapsed, restoring division by the divisor input,
// saturating accumulate. Depends on itgi_pkg.
module itgi_axis
    import itgi_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [RATE_W-1:0]    rate,
    input  logic [TIME_W-1:0]           elapsed,
    input  logic [DIV_W-1:0]            divisor,
    output logic                        done,
    output logic signed [ACC_WIDTH-1:0] sum
);

    localparam int NB   = PROD_W + FRAC_BITS;
    localparam int EW   = (NB > 64) ? NB : 64;
    localparam int SW   = 66;
    localparam int CNTW = $clog2(NB + 1);

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_MUL  = 2'd1;
    localparam logic [1:0] A_DIV  = 2'd2;
    localparam logic [1:0] A_ACC  = 2'd3;

    localparam logic signed [SW-1:0] AMAX =
        {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] AMIN = ~AMAX;

    logic [1:0]              phase_reg, phase_next;
    logic [CNTW-1:0]         cnt_reg, cnt_next;
    logic [RATE_W-1:0]       mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic [TIME_W-1:0]       elap_reg, elap_next;
    logic [DIV_W-1:0]        div_reg, div_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [NB-1:0]           num_reg, num_next;
    logic [DIV_W-1:0]        rem_reg, rem_next;
    logic signed [ACC_WIDTH-1:0] sum_reg, sum_next;
    logic                    done_reg, done_next;

    logic [PROD_W-1:0]       prod_step;
    logic [DIV_W:0]          rem_sh;
    logic                    qbit;
    logic [EW-1:0]           q_ext;
    logic                    sat;
    logic [62:0]             mag63;
    logic signed [SW-1:0]    inc_wide;
    logic signed [SW-1:0]    tot;

    always_comb
    begin
        prod_step = {prod_reg[PROD_W-2:0], 1'b0}
                  + (mag_reg[RATE_W-1] ? PROD_W'(elap_reg) : '0);
        rem_sh    = {rem_reg, num_reg[NB-1]};
        qbit      = (rem_sh >= {1'b0, div_reg});
        q_ext     = EW'(num_reg);
        sat       = |q_ext[EW-1:63];
        mag63     = sat ? {63{1'b1}} : q_ext[62:0];
        inc_wide  = {3'b000, mag63};
        if (neg_reg)
            inc_wide = -inc_wide;
        tot = SW'(sum_reg) + inc_wide;
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        elap_next  = elap_reg;
        div_next   = div_reg;
        prod_next  = prod_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        sum_next   = sum_reg;
        done_next  = 1'b0;
        case (phase_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    neg_next   = rate[RATE_W-1];
                    mag_next   = rate[RATE_W-1] ? (~rate + 1'b1) : rate;
                    elap_next  = elapsed;
                    div_next   = divisor;
                    prod_next  = '0;
                    cnt_next   = '0;
                    phase_next = A_MUL;
                end
            end
            A_MUL:
            begin
                prod_next = prod_step;
                mag_next  = {mag_reg[RATE_W-2:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(RATE_W - 1))
                begin
                    num_next   = {prod_step, {FRAC_BITS{1'b0}}};
                    rem_next   = '0;
                    cnt_next   = '0;
                    phase_next = A_DIV;
                end
            end
            A_DIV:
            begin
                rem_next = qbit ? DIV_W'(rem_sh - {1'b0, div_reg}) : rem_sh[DIV_W-1:0];
                num_next = {num_reg[NB-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(NB - 1))
                    phase_next = A_ACC;
            end
            A_ACC:
            begin
                if (tot > AMAX)
                    sum_next = AMAX[ACC_WIDTH-1:0];
                else if (tot < AMIN)
                    sum_next = AMIN[ACC_WIDTH-1:0];
                else
                    sum_next = tot[ACC_WIDTH-1:0];
                done_next  = 1'b1;
                phase_next = A_IDLE;
            end
            default:
            begin
                phase_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= A_IDLE;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        elap_reg <= elap_next;
        div_reg  <= div_next;
        prod_reg <= prod_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign sum  = sum_reg;

endmodule

FILE: hdl/itgi_tilt.sv
// Accelerometer tilt: squares, bit-pair square root and iterative vectoring CORDIC
// for roll and pitch. Depends on itgi_pkg.
module itgi_tilt
    import itgi_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [RATE_W-1:0] accel_x,
    input  logic signed [RATE_W-1:0] accel_y,
    input  logic signed [RATE_W-1:0] accel_z,
    output tilt_t                    result
);

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_SQ   = 3'd1;
    localparam logic [2:0] T_SUM  = 3'd2;
    localparam logic [2:0] T_ROOT = 3'd3;
    localparam logic [2:0] T_PIT  = 3'd4;
    localparam logic [2:0] T_CORD = 3'd5;
    localparam logic [2:0] T_OUT  = 3'd6;

    localparam logic [4:0] CORD_LAST = 5'(CORDIC_STEPS - 1);
    localparam logic [4:0] ROOT_LAST = 5'(ROOT_STEPS - 1);

    logic [2:0]                 phase_reg, phase_next;
    logic [4:0]                 cnt_reg, cnt_next;
    logic signed [RATE_W-1:0]   ax_reg, ax_next;
    logic signed [RATE_W-1:0]   ay_reg, ay_next;
    logic signed [RATE_W-1:0]   az_reg, az_next;
    logic [31:0]                sqy_reg, sqy_next;
    logic [31:0]                sqz_reg, sqz_next;
    logic [ROOT_W-1:0]          v_reg, v_next;
    logic [ROOT_W-1:0]          r_reg, r_next;
    logic [ROOT_W-1:0]          bit_reg, bit_next;
    cvec_t                      vec_reg, vec_next;
    ang_t                       rollz_reg, rollz_next;
    logic                       rzero_reg, rzero_next;
    tilt_t                      res_reg, res_next;

    logic signed [31:0]         py;
    logic signed [31:0]         pz;
    logic [ROOT_W-1:0]          root_t;
    cvec_t                      vec_step;
    cvec_t                      roll_init;
    cord_t                      ay_sh;
    cord_t                      az_sh;
    logic                       pzero;
    logic signed [ROLL_W-1:0]   pitch_full;

    always_comb
    begin
        py       = ay_reg * ay_reg;
        pz       = az_reg * az_reg;
        root_t   = r_reg + bit_reg;
        vec_step = cordic_step(vec_reg, cnt_reg);
        ay_sh    = cord_t'(accel_y) <<< 20;
        az_sh    = cord_t'(accel_z) <<< 20;
        if (!accel_z[RATE_W-1])
        begin
            roll_init.x = az_sh;
            roll_init.y = ay_sh;
            roll_init.z = '0;
        end
        else if (!accel_y[RATE_W-1])
        begin
            roll_init.x = ay_sh;
            roll_init.y = -az_sh;
            roll_init.z = DEG90_Z;
        end
        else
        begin
            roll_init.x = -ay_sh;
            roll_init.y = az_sh;
            roll_init.z = -DEG90_Z;
        end
        pzero      = (r_reg == '0) && (ax_reg == '0);
        pitch_full = round_clamp(vec_reg.z, PITCH_LIM);
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        az_next    = az_reg;
        sqy_next   = sqy_reg;
        sqz_next   = sqz_reg;
        v_next     = v_reg;
        r_next     = r_reg;
        bit_next   = bit_reg;
        vec_next   = vec_reg;
        rollz_next = rollz_reg;
        rzero_next = rzero_reg;
        res_next   = res_reg;
        res_next.done = 1'b0;
        case (phase_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    ax_next    = accel_x;
                    ay_next    = accel_y;
                    az_next    = accel_z;
                    vec_next   = roll_init;
                    rzero_next = (accel_y == '0) && (accel_z == '0);
                    phase_next = T_SQ;
                end
            end
            T_SQ:
            begin
                sqy_next   = py;
                sqz_next   = pz;
                phase_next = T_SUM;
            end
            T_SUM:
            begin
                v_next     = {sqy_reg + sqz_reg, 16'b0};
                r_next     = '0;
                bit_next   = ROOT_W'(1) << (2 * (ROOT_STEPS - 1));
                cnt_next   = '0;
                phase_next = T_ROOT;
            end
            T_ROOT:
            begin
                if (v_reg >= root_t)
                begin
                    v_next = v_reg - root_t;
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (cnt_reg <= CORD_LAST)
                    vec_next = vec_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ROOT_LAST)
                    phase_next = T_PIT;
            end
            T_PIT:
            begin
                rollz_next = vec_reg.z;
                vec_next.x = cord_t'({{(CW-24){1'b0}}, r_reg[23:0]}) <<< 12;
                vec_next.y = -(cord_t'(ax_reg) <<< 20);
                vec_next.z = '0;
                cnt_next   = '0;
                phase_next = T_CORD;
            end
            T_CORD:
            begin
                vec_next = vec_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CORD_LAST)
                    phase_next = T_OUT;
            end
            T_OUT:
            begin
                res_next.roll  = rzero_reg ? '0 : round_clamp(rollz_reg, ROLL_LIM);
                res_next.pitch = pzero ? '0 : pitch_full[PITCH_W-1:0];
                res_next.done  = 1'b1;
                phase_next     = T_IDLE;
            end
            default:
            begin
                phase_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= T_IDLE;
            cnt_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg        <= ax_next;
        ay_reg        <= ay_next;
        az_reg        <= az_next;
        sqy_reg       <= sqy_next;
        sqz_reg       <= sqz_next;
        v_reg         <= v_next;
        r_reg         <= r_next;
        bit_reg       <= bit_next;
        vec_reg       <= vec_next;
        rollz_reg     <= rollz_next;
        rzero_reg     <= rzero_next;
    end

    assign result = res_reg;

endmodule

FILE: hdl/imu_tilt_and_gyro_integrator.sv
// Top level: IMU sample in, integrated gyro angles and accelerometer tilt out.
// Depends on itgi_pkg, itgi_axis and itgi_tilt.
//
//  channel | handshake               | beat
//  in      | in_valid / in_stall     | accel_x/y/z, rate_x/y/z, time_ms
//  out     | out_valid / out_stall   | stamp_ms, gyro_angle_x/y/z, roll_deg, pitch_deg
//  cfg     | cfg_wr_en               | cfg_wr_data (gyro_sensitivity)
//
// The bit-serial multiply and restoring divide of the axis units set how long a sample
// takes at the default parameters; the tilt unit runs alongside them.
// A sample with zero elapsed time is accepted but starts no work and gives no beat.
// Reset clears the timestamp and angle sums and sets the sensitivity to 1310.
// A finished result waits in the output register while the next sample is accepted.
module imu_tilt_and_gyro_integrator
    import itgi_pkg::*;
#(
    parameter int ACC_WIDTH       = ACC_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [RATE_W-1:0]      accel_x,
    input  logic signed [RATE_W-1:0]      accel_y,
    input  logic signed [RATE_W-1:0]      accel_z,
    input  logic signed [RATE_W-1:0]      rate_x,
    input  logic signed [RATE_W-1:0]      rate_y,
    input  logic signed [RATE_W-1:0]      rate_z,
    input  logic [TIME_W-1:0]             time_ms,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [TIME_W-1:0]             stamp_ms,
    output logic signed [ANGLE_OUT_W-1:0] gyro_angle_x,
    output logic signed [ANGLE_OUT_W-1:0] gyro_angle_y,
    output logic signed [ANGLE_OUT_W-1:0] gyro_angle_z,
    output logic signed [ROLL_W-1:0]      roll_deg,
    output logic signed [PITCH_W-1:0]     pitch_deg,
    input  logic                          cfg_wr_en,
    input  logic [SENS_W-1:0]             cfg_wr_data
);

    localparam int XW = (ACC_WIDTH > ANGLE_OUT_W) ? ACC_WIDTH : ANGLE_OUT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [TIME_W-1:0]       last_reg, last_next;
    logic [SENS_W-1:0]       sens_reg, sens_next;
    logic [TIME_W-1:0]       stamp_reg, stamp_next;
    logic [2:0]              axdone_reg, axdone_next;
    logic                    tdone_reg, tdone_next;
    logic                    ovalid_reg, ovalid_next;
    logic [TIME_W-1:0]       ostamp_reg;
    logic signed [ANGLE_OUT_W-1:0] oang_reg [3];
    logic signed [ROLL_W-1:0]  oroll_reg;
    logic signed [PITCH_W-1:0] opitch_reg;

    logic                    accept;
    logic                    start;
    logic                    load;
    logic [TIME_W-1:0]       elapsed;
    logic [SENS_W-1:0]       sens_eff;
    logic [DIV_W-1:0]        divisor;
    logic signed [RATE_W-1:0] rate_arr [3];
    logic [2:0]              ax_done;
    logic signed [ACC_WIDTH-1:0] sum_arr [3];
    logic signed [XW-1:0]    sum_ext [3];
    tilt_t                   tilt;

    assign accept   = in_valid && !in_stall;
    assign elapsed  = time_ms - last_reg;
    assign start    = accept && (elapsed != '0);
    assign sens_eff = (sens_reg == '0) ? SENS_W'(1) : sens_reg;
    assign divisor  = {1'b0, sens_eff, 6'b0} + {2'b0, sens_eff, 5'b0}
                    + {5'b0, sens_eff, 2'b0};
    assign rate_arr[0] = rate_x;
    assign rate_arr[1] = rate_y;
    assign rate_arr[2] = rate_z;

    for (genvar g = 0; g < 3; g++)
    begin : g_axis
        itgi_axis #(
            .ACC_WIDTH (ACC_WIDTH),
            .FRAC_BITS (ANGLE_FRAC_BITS)
        ) u_axis (
            .clk     (clk),
            .rst_n   (rst_n),
            .start   (start),
            .rate    (rate_arr[g]),
            .elapsed (elapsed),
            .divisor (divisor),
            .done    (ax_done[g]),
            .sum     (sum_arr[g])
        );
        assign sum_ext[g] = XW'(sum_arr[g]);
    end

    itgi_tilt #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_tilt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .accel_x (accel_x),
        .accel_y (accel_y),
        .accel_z (accel_z),
        .result  (tilt)
    );

    always_comb
    begin
        state_next  = state_reg;
        last_next   = last_reg;
        sens_next   = cfg_wr_en ? cfg_wr_data : sens_reg;
        stamp_next  = stamp_reg;
        axdone_next = axdone_reg | ax_done;
        tdone_next  = tdone_reg | tilt.done;
        load        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    last_next = time_ms;
                if (start)
                begin
                    stamp_next  = time_ms;
                    axdone_next = '0;
                    tdone_next  = 1'b0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if ((&axdone_reg) && tdone_reg)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (load)
            ovalid_next = 1'b1;
        else if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;
        else
            ovalid_next = ovalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            last_reg   <= '0;
            sens_reg   <= SENS_RESET;
            axdone_reg <= '0;
            tdone_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            last_reg   <= last_next;
            sens_reg   <= sens_next;
            axdone_reg <= axdone_next;
            tdone_reg  <= tdone_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stamp_reg <= stamp_next;
        if (load)
        begin
            ostamp_reg  <= stamp_reg;
            oang_reg[0] <= sum_ext[0][ANGLE_OUT_W-1:0];
            oang_reg[1] <= sum_ext[1][ANGLE_OUT_W-1:0];
            oang_reg[2] <= sum_ext[2][ANGLE_OUT_W-1:0];
            oroll_reg   <= tilt.roll;
            opitch_reg  <= tilt.pitch;
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = ovalid_reg;
    assign stamp_ms     = ostamp_reg;
    assign gyro_angle_x = oang_reg[0];
    assign gyro_angle_y = oang_reg[1];
    assign gyro_angle_z = oang_reg[2];
    assign roll_deg     = oroll_reg;
    assign pitch_deg    = opitch_reg;

    a_zero_elapsed_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (elapsed == '0)) |=> (state_reg == ST_IDLE))
        else $error("zero elapsed sample started work");

    a_done_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        ((|ax_done) || tilt.done) |-> (state_reg == ST_RUN))
        else $error("unit finished outside a run");

    a_hold_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_HOLD) && (!ovalid_reg || !out_stall)) |=> out_valid)
        else $error("finished result not presented");

endmodule
